// ----- sv/fatan2_pkg.sv -----
package fatan2_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAG_W        = SAMPLE_WIDTH;
    localparam int S_TDATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ANGLE_W      = 16;
    localparam int M_TDATA_W    = ((ANGLE_W + 7) / 8) * 8;

    // ratio magnitude, Q1.15 in 0..32768
    localparam int Q_W   = 16;
    // approximation magnitude, Q1.13 in 0..8192
    localparam int A_W   = 14;
    // 1 + 0.28 r^2, Q1.15 in 32768..41943
    localparam int DEN_W = 16;
    localparam int COEF_W = 14;

    localparam logic [COEF_W-1:0]         COEF_Q15    = 14'd9175;
    localparam logic [DEN_W-1:0]          ONE_Q15     = 16'd32768;
    localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

    // pipeline stage numbers
    localparam int ST_IN  = 1;
    localparam int ST_MAG = 2;
    localparam int ST_SEL = 3;
    localparam int ST_D1E = ST_SEL + Q_W;
    localparam int ST_SQ  = ST_D1E + 1;
    localparam int ST_CP  = ST_SQ + 1;
    localparam int ST_DEN = ST_CP + 1;
    localparam int ST_D2E = ST_DEN + A_W;
    localparam int ST_SGN = ST_D2E + 1;
    localparam int ST_SUM = ST_SGN + 1;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
        logic br1;   // |y| < |x|: ratio is y/x
        logic rneg;  // ratio is negative
    } fa2_ctl_t;

endpackage

// ----- sv/fast_atan2_phase_unit.sv -----
// Throughput: one item per cycle unless stalled; 16 restoring divide stages for the ratio and 14 for
// the approximation, one quotient bit per stage, plus two multiply stages.
// Stalls: freezes only when the last stage and output register hold items and m_tready is low.
// Reset: aresetn synchronous, active low; clears the valid bits, pipeline empties.
module fast_atan2_phase_unit
    import fatan2_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_in, y_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // angle
);

    logic                      adv;
    logic [ST_SUM:ST_IN]       vld_reg;
    fa2_ctl_t                  ctl_reg [ST_MAG:ST_D2E];

    logic [SAMPLE_WIDTH-1:0]   x_reg, y_reg;
    logic [MAG_W-1:0]          ax_reg, ay_reg;
    fa2_ctl_t                  ctl_mag_next, ctl_sel_next;
    logic [MAG_W-1:0]          ax_next, ay_next;

    logic [MAG_W-1:0]          d1_rem_reg [0:Q_W-1];
    logic [MAG_W-1:0]          d1_den_reg [0:Q_W-1];
    logic [Q_W-1:0]            d1_q_reg   [1:Q_W];

    logic [2*Q_W-1:0]          sq_prod;
    logic [Q_W-1:0]            sq_reg, q_sq_reg, q_cp_reg;
    logic [COEF_W+Q_W-1:0]     cp_prod;
    logic [COEF_W-1:0]         cpsh_reg;

    logic [DEN_W-1:0]          d2_rem_reg [0:A_W-1];
    logic [DEN_W-1:0]          d2_den_reg [0:A_W-1];
    logic [A_W-1:0]            d2_q_reg   [1:A_W];

    logic                      neg_sel;
    logic signed [ANGLE_W-1:0] t_next, off_next;
    logic signed [ANGLE_W-1:0] t_reg, off_reg, sum_reg;

    logic                      m_tvalid_reg;
    logic [ANGLE_W-1:0]        m_angle_reg;

    assign adv      = ~vld_reg[ST_SUM] | ~m_tvalid_reg | m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_angle_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ST_SUM-1:ST_IN], s_tvalid};
        end
    end

    // input, magnitudes, branch select
    always_comb begin
        ax_next = x_reg[SAMPLE_WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
        ay_next = y_reg[SAMPLE_WIDTH-1] ? (~y_reg + 1'b1) : y_reg;
        ctl_mag_next.xneg  = x_reg[SAMPLE_WIDTH-1];
        ctl_mag_next.yneg  = y_reg[SAMPLE_WIDTH-1];
        ctl_mag_next.xzero = (x_reg == '0);
        ctl_mag_next.yzero = (y_reg == '0);
        ctl_mag_next.br1   = 1'b0;
        ctl_mag_next.rneg  = x_reg[SAMPLE_WIDTH-1] ^ y_reg[SAMPLE_WIDTH-1];
        ctl_sel_next       = ctl_reg[ST_MAG];
        ctl_sel_next.br1   = (ay_reg < ax_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg            <= s_tdata[SAMPLE_WIDTH-1:0];
            y_reg            <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            ax_reg           <= ax_next;
            ay_reg           <= ay_next;
            ctl_reg[ST_MAG]  <= ctl_mag_next;
            ctl_reg[ST_SEL]  <= ctl_sel_next;
            d1_rem_reg[0]    <= ctl_sel_next.br1 ? ay_reg : ax_reg;
            d1_den_reg[0]    <= ctl_sel_next.br1 ? ax_reg : ay_reg;
        end
    end

    genvar k;
    for (k = ST_SEL + 1; k <= ST_D2E; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (adv) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // ratio divider: floor(num * 2^15 / den), num <= den, MSB first
    for (k = 0; k < Q_W; k++) begin : g_div1
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic [Q_W-1:0]   q_prev;
        if (k == 0) begin : g_first
            assign trial  = {1'b0, d1_rem_reg[k]};
            assign q_prev = '0;
        end else begin : g_rest
            assign trial  = {d1_rem_reg[k], 1'b0};
            assign q_prev = d1_q_reg[k];
        end
        assign diff = trial - {1'b0, d1_den_reg[k]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                d1_q_reg[k+1] <= {q_prev[Q_W-2:0], ~diff[MAG_W]};
            end
        end
        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    d1_den_reg[k+1] <= d1_den_reg[k];
                    d1_rem_reg[k+1] <= diff[MAG_W] ? trial[MAG_W-1:0] : diff[MAG_W-1:0];
                end
            end
        end
    end

    // denominator: 1 + 0.28 r^2
    assign sq_prod = (2*Q_W)'(d1_q_reg[Q_W]) * (2*Q_W)'(d1_q_reg[Q_W]);
    assign cp_prod = (COEF_W+Q_W)'(COEF_Q15) * (COEF_W+Q_W)'(sq_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg        <= sq_prod[2*Q_W-2:Q_W-1];
            q_sq_reg      <= d1_q_reg[Q_W];
            cpsh_reg      <= cp_prod[COEF_W+Q_W-2:Q_W-1];
            q_cp_reg      <= q_sq_reg;
            d2_rem_reg[0] <= q_cp_reg;
            d2_den_reg[0] <= ONE_Q15 + {{(DEN_W-COEF_W){1'b0}}, cpsh_reg};
        end
    end

    // approximation divider: floor(r * 2^13 / denom), r <= denom
    for (k = 0; k < A_W; k++) begin : g_div2
        logic [DEN_W+1:0] trial;
        logic [DEN_W+1:0] diff;
        logic [A_W-1:0]   q_prev;
        if (k == 0) begin : g_first
            assign trial  = {2'b00, d2_rem_reg[k]};
            assign q_prev = '0;
        end else begin : g_rest
            assign trial  = {1'b0, d2_rem_reg[k], 1'b0};
            assign q_prev = d2_q_reg[k];
        end
        assign diff = trial - {2'b00, d2_den_reg[k]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                d2_q_reg[k+1] <= {q_prev[A_W-2:0], ~diff[DEN_W+1]};
            end
        end
        if (k < A_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    d2_den_reg[k+1] <= d2_den_reg[k];
                    d2_rem_reg[k+1] <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
                end
            end
        end
    end

    // quadrant: zero x gives 0 or +-pi/2; br1 gives +-a + off, otherwise pi/2 - (+-a) - (y<0 ? pi : 0)
    always_comb begin
        neg_sel = ctl_reg[ST_D2E].br1 ? ctl_reg[ST_D2E].rneg : ~ctl_reg[ST_D2E].rneg;
        t_next  = neg_sel ? -$signed({{(ANGLE_W-A_W){1'b0}}, d2_q_reg[A_W]})
                          :  $signed({{(ANGLE_W-A_W){1'b0}}, d2_q_reg[A_W]});
        if (ctl_reg[ST_D2E].xzero) begin
            t_next = '0;
        end
        priority if (ctl_reg[ST_D2E].xzero) begin
            if (ctl_reg[ST_D2E].yzero) begin
                off_next = '0;
            end else begin
                off_next = ctl_reg[ST_D2E].yneg ? -HALF_PI_Q13 : HALF_PI_Q13;
            end
        end else if (ctl_reg[ST_D2E].br1) begin
            if (ctl_reg[ST_D2E].xneg) begin
                off_next = ctl_reg[ST_D2E].yneg ? -PI_Q13 : PI_Q13;
            end else begin
                off_next = '0;
            end
        end else begin
            off_next = ctl_reg[ST_D2E].yneg ? (HALF_PI_Q13 - PI_Q13) : HALF_PI_Q13;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg   <= t_next;
            off_reg <= off_next;
            sum_reg <= t_reg + off_reg;
        end
    end

    // output register: a waiting item stays until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[ST_SUM];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[ST_SUM]) begin
            m_angle_reg <= sum_reg;
        end
    end

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[ANGLE_W-1:0]) <= PI_Q13 &&
                      $signed(m_tdata[ANGLE_W-1:0]) >= -PI_Q13))
        else $error("angle out of range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && vld_reg[ST_SUM]))
        else $error("input stalled without a blocked output");

    // zero x divides zero by |y|, or by zero if y is zero; that quotient is discarded
    a_ratio_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_D1E] && !ctl_reg[ST_D1E].xzero) |-> (d1_q_reg[Q_W] <= ONE_Q15))
        else $error("ratio exceeds one");

    a_approx_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_D2E] && !ctl_reg[ST_D2E].xzero) |-> (d2_q_reg[A_W] <= A_W'(8192)))
        else $error("approximation exceeds one");
`endif

endmodule
